@@ sv/tpsm_pkg.sv @@
// Shared types and constants for the triangle plane slice midpoint block.
package tpsm_pkg;

    localparam int COORD_W    = 32;
    localparam int NORM_W     = 16;
    localparam int TOL_W      = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int DIV_STAGES = COORD_W;
    localparam int LANES      = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 9 * COORD_W + 3 * NORM_W;
    localparam int OUT_DATA_W = 3 * COORD_W + 3 * NORM_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [NORM_W-1:0]  nz;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nx;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] ax;
    } tri_t;

    // One point: x0 + num * dx / den, z given directly
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  num;
        logic signed [DIFF_W-1:0]  den;
        logic signed [COORD_W-1:0] z;
    } pt_t;

    typedef struct packed {
        pt_t                      p0;
        pt_t                      p1;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } job_t;

    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] c0;
        logic [LANES-1:0]              neg;
        logic signed [COORD_W-1:0]     z0;
        logic signed [COORD_W-1:0]     z1;
        logic signed [NORM_W-1:0]      nx;
        logic signed [NORM_W-1:0]      ny;
        logic signed [NORM_W-1:0]      nz;
    } side_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]  nz;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nx;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_x;
    } res_t;

    function automatic logic [COORD_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] m;
        m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return m[COORD_W-1:0];
    endfunction

endpackage

@@ sv/tpsm_front.sv @@
// Front end: edge crossing and on-plane classification, point setup.
module tpsm_front (
    input  tpsm_pkg::tri_t                    tri_in,
    input  logic signed [tpsm_pkg::COORD_W-1:0] height,
    input  logic [tpsm_pkg::TOL_W-1:0]        tolerance,
    output logic                              emit,
    output tpsm_pkg::job_t                    job
);
    import tpsm_pkg::*;

    function automatic pt_t make_edge(
        input logic signed [COORD_W-1:0] p0x, p0y, p0z, p1x, p1y, p1z,
        input logic signed [COORD_W-1:0] h
    );
        pt_t p;
        p.x0  = p0x;
        p.y0  = p0y;
        p.dx  = DIFF_W'(p1x) - DIFF_W'(p0x);
        p.dy  = DIFF_W'(p1y) - DIFF_W'(p0y);
        p.num = DIFF_W'(h) - DIFF_W'(p0z);
        p.den = DIFF_W'(p1z) - DIFF_W'(p0z);
        p.z   = h;
        return p;
    endfunction

    function automatic pt_t make_vtx(input logic signed [COORD_W-1:0] x, y, z);
        pt_t p;
        p.x0  = x;
        p.y0  = y;
        p.dx  = '0;
        p.dy  = '0;
        p.num = '0;
        p.den = DIFF_W'(1);
        p.z   = z;
        return p;
    endfunction

    function automatic logic crosses(input logic signed [DIFF_W-1:0] d0, d1);
        return (d0 < 0 && d1 > 0) || (d0 > 0 && d1 < 0);
    endfunction

    logic signed [DIFF_W-1:0] d_a, d_b, d_c;
    logic x_ab, x_bc, x_ca;
    logic o_a, o_b, o_c;
    pt_t  e_ab, e_bc, e_ca, v_a, v_b, v_c;

    assign d_a = DIFF_W'(tri_in.az) - DIFF_W'(height);
    assign d_b = DIFF_W'(tri_in.bz) - DIFF_W'(height);
    assign d_c = DIFF_W'(tri_in.cz) - DIFF_W'(height);

    assign x_ab = crosses(d_a, d_b);
    assign x_bc = crosses(d_b, d_c);
    assign x_ca = crosses(d_c, d_a);

    assign o_a = {1'b0, mag33(d_a)} < (COORD_W + 1)'(tolerance);
    assign o_b = {1'b0, mag33(d_b)} < (COORD_W + 1)'(tolerance);
    assign o_c = {1'b0, mag33(d_c)} < (COORD_W + 1)'(tolerance);

    assign e_ab = make_edge(tri_in.ax, tri_in.ay, tri_in.az,
                            tri_in.bx, tri_in.by, tri_in.bz, height);
    assign e_bc = make_edge(tri_in.bx, tri_in.by, tri_in.bz,
                            tri_in.cx, tri_in.cy, tri_in.cz, height);
    assign e_ca = make_edge(tri_in.cx, tri_in.cy, tri_in.cz,
                            tri_in.ax, tri_in.ay, tri_in.az, height);
    assign v_a  = make_vtx(tri_in.ax, tri_in.ay, tri_in.az);
    assign v_b  = make_vtx(tri_in.bx, tri_in.by, tri_in.bz);
    assign v_c  = make_vtx(tri_in.cx, tri_in.cy, tri_in.cz);

    always_comb
    begin
        job.nx = tri_in.nx;
        job.ny = tri_in.ny;
        job.nz = tri_in.nz;
        if (x_ab || x_bc || x_ca)
        begin
            emit   = (x_ab && x_bc) || (x_ab && x_ca) || (x_bc && x_ca);
            job.p0 = x_ab ? e_ab : e_bc;
            job.p1 = (x_ab && x_bc) ? e_bc : e_ca;
        end
        else
        begin
            emit   = (o_a && o_b) || (o_a && o_c) || (o_b && o_c);
            job.p0 = o_a ? v_a : v_b;
            job.p1 = (o_a && o_b) ? v_b : v_c;
        end
    end

endmodule

@@ sv/tpsm_queue.sv @@
// Job queue between the front end and the arithmetic back end.
module tpsm_queue #(
    parameter int DEPTH = tpsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tpsm_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tpsm_pkg::job_t pop_data
);
    import tpsm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ sv/tpsm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module tpsm_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [tpsm_pkg::PROD_W-1:0]    dividend,
    input  logic [tpsm_pkg::COORD_W-1:0]   divisor,
    output logic [tpsm_pkg::COORD_W-1:0]   quotient
);
    import tpsm_pkg::*;

    logic [COORD_W-1:0] rem_reg [DIV_STAGES];
    logic [COORD_W-1:0] lo_reg  [DIV_STAGES];
    logic [COORD_W-1:0] quo_reg [DIV_STAGES];
    logic [COORD_W-1:0] dvs_reg [DIV_STAGES];
    logic [COORD_W-1:0] rem_next [DIV_STAGES];
    logic [COORD_W-1:0] lo_next  [DIV_STAGES];
    logic [COORD_W-1:0] quo_next [DIV_STAGES];
    logic [COORD_W-1:0] dvs_next [DIV_STAGES];

    always_comb
    begin
        logic [COORD_W-1:0] r, lo, q, d;
        logic [COORD_W:0]   t;
        logic               ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r  = dividend[PROD_W-1:COORD_W];
                lo = dividend[COORD_W-1:0];
                q  = '0;
                d  = divisor;
            end
            else
            begin
                r  = rem_reg[s-1];
                lo = lo_reg[s-1];
                q  = quo_reg[s-1];
                d  = dvs_reg[s-1];
            end
            t  = {r, lo[COORD_W-1]};
            ge = t >= {1'b0, d};
            rem_next[s] = ge ? COORD_W'(t - {1'b0, d}) : t[COORD_W-1:0];
            lo_next[s]  = {lo[COORD_W-2:0], 1'b0};
            quo_next[s] = {q[COORD_W-2:0], ge};
            dvs_next[s] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_next;
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

@@ sv/tpsm_back.sv @@
// Back end: products, division lanes, point reconstruction and midpoint.
module tpsm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  tpsm_pkg::job_t job,
    output logic           res_valid,
    input  logic           res_ready,
    output tpsm_pkg::res_t res
);
    import tpsm_pkg::*;

    logic                 advance, load;
    logic [PROD_W-1:0]    prod_reg [LANES];
    logic [COORD_W-1:0]   dvs_reg  [2];
    side_t                side_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0]  vld_reg;
    logic [COORD_W-1:0]   quo [LANES];
    logic [COORD_W-1:0]   crd_reg [LANES];
    logic signed [COORD_W-1:0] z0_reg, z1_reg;
    logic signed [NORM_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic                 crd_valid_reg, out_valid_reg;
    res_t                 res_reg;
    side_t                side_in;
    logic [COORD_W-1:0]   c0_in [LANES];
    logic signed [DIFF_W-1:0] d_in [LANES];
    logic signed [DIFF_W-1:0] num_in [LANES];
    logic signed [DIFF_W-1:0] den_in [LANES];

    assign advance   = !out_valid_reg || res_ready;
    assign job_ready = advance;
    assign load      = job_valid && advance;

    assign c0_in[0] = job.p0.x0;  assign d_in[0] = job.p0.dx;
    assign c0_in[1] = job.p0.y0;  assign d_in[1] = job.p0.dy;
    assign c0_in[2] = job.p1.x0;  assign d_in[2] = job.p1.dx;
    assign c0_in[3] = job.p1.y0;  assign d_in[3] = job.p1.dy;
    assign num_in[0] = job.p0.num; assign den_in[0] = job.p0.den;
    assign num_in[1] = job.p0.num; assign den_in[1] = job.p0.den;
    assign num_in[2] = job.p1.num; assign den_in[2] = job.p1.den;
    assign num_in[3] = job.p1.num; assign den_in[3] = job.p1.den;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            side_in.c0[k]  = c0_in[k];
            side_in.neg[k] = num_in[k][DIFF_W-1] ^ d_in[k][DIFF_W-1] ^ den_in[k][DIFF_W-1];
        end
        side_in.z0 = job.p0.z;
        side_in.z1 = job.p1.z;
        side_in.nx = job.nx;
        side_in.ny = job.ny;
        side_in.nz = job.nz;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < LANES; k++)
                prod_reg[k] <= PROD_W'(mag33(num_in[k])) * PROD_W'(mag33(d_in[k]));
            dvs_reg[0]  <= mag33(job.p0.den);
            dvs_reg[1]  <= mag33(job.p1.den);
            side_reg[0] <= side_in;
            for (int s = 0; s < DIV_STAGES; s++)
                side_reg[s+1] <= side_reg[s];
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        tpsm_div u_div (
            .clk      (clk),
            .en       (advance),
            .dividend (prod_reg[k]),
            .divisor  (dvs_reg[k/2]),
            .quotient (quo[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < LANES; k++)
                crd_reg[k] <= side_reg[DIV_STAGES].neg[k]
                    ? COORD_W'(side_reg[DIV_STAGES].c0[k] - quo[k])
                    : COORD_W'(side_reg[DIV_STAGES].c0[k] + quo[k]);
            z0_reg <= side_reg[DIV_STAGES].z0;
            z1_reg <= side_reg[DIV_STAGES].z1;
            nx_reg <= side_reg[DIV_STAGES].nx;
            ny_reg <= side_reg[DIV_STAGES].ny;
            nz_reg <= side_reg[DIV_STAGES].nz;

            res_reg.mid_x <= COORD_W'((DIFF_W'(signed'(crd_reg[0]))
                                     + DIFF_W'(signed'(crd_reg[2]))) >>> 1);
            res_reg.mid_y <= COORD_W'((DIFF_W'(signed'(crd_reg[1]))
                                     + DIFF_W'(signed'(crd_reg[3]))) >>> 1);
            res_reg.mid_z <= COORD_W'((DIFF_W'(z0_reg) + DIFF_W'(z1_reg)) >>> 1);
            res_reg.nx    <= nx_reg;
            res_reg.ny    <= ny_reg;
            res_reg.nz    <= nz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            crd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[DIV_STAGES-1:0], load};
            crd_valid_reg <= vld_reg[DIV_STAGES];
            out_valid_reg <= crd_valid_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg) && $stable(crd_valid_reg))
        else $error("pipeline moved while stalled");
    a_load_enters: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> vld_reg[0])
        else $error("accepted job lost at product stage");
    a_last_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && crd_valid_reg) |=> out_valid_reg)
        else $error("finished point not presented");

endmodule

@@ sv/triangle_plane_slice_midpoint_top.sv @@
// Top level of the triangle plane slice midpoint block.
//
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  triangle and face normal (tdata, 336 bits)
// m_       out        m_tvalid/m_tready  midpoint and normal (tdata, 144 bits)
// cfg_     in         cfg_valid/cfg_ready register index and write data
//
// One triangle accepted per cycle while the queue has room (s_tready high); a result passes
// through the product stage, the 32-stage quotient pipeline, then the point and midpoint stages.
// Triangles that yield no result are dropped in the front end at acceptance.
// Reset clears the queue and pipeline valids; height resets to 0, tolerance to 1.
// A stall on m_ freezes the back end; the queue then fills and stops s_.
module triangle_plane_slice_midpoint_top #(
    parameter int QUEUE_DEPTH = tpsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_nx, face_ny, face_nz
    input  logic [tpsm_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // mid_x, mid_y, mid_z, out_nx, out_ny, out_nz
    output logic [tpsm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tpsm_pkg::*;

    logic signed [COORD_W-1:0] height_reg;
    logic [TOL_W-1:0]          tol_reg;
    tri_t  tri_in;
    job_t  front_job, q_job;
    logic  emit, q_push_ready, q_pop_valid, q_pop_ready;
    res_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
            tol_reg    <= TOL_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SLICE_HEIGHT: height_reg <= cfg_data[COORD_W-1:0];
                REG_TOLERANCE:    tol_reg    <= cfg_data[TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign tri_in   = s_tdata;
    assign s_tready = q_push_ready;

    tpsm_front u_front (
        .tri_in    (tri_in),
        .height    (height_reg),
        .tolerance (tol_reg),
        .emit      (emit),
        .job       (front_job)
    );

    tpsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid && emit),
        .push_ready (q_push_ready),
        .push_data  (front_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_job)
    );

    tpsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_pop_valid),
        .job_ready (q_pop_ready),
        .job       (q_job),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res;

endmodule
